// ----- hw/rtl/fqdm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fqdm_pkg: shared types for the drop-above-mean queue
// Operation and status codes and the sequencer states.
// ----------------------------------------------------------------------------
package fqdm_pkg;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_DROP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_SUM,
		S_DIV,
		S_FILT
	} state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fqdm_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fqdm_in_if: command channel
// Valid/ready channel carrying one queue operation per beat.
// ----------------------------------------------------------------------------
interface fqdm_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   op;
	logic signed [DATA_WIDTH-1:0] push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink   (input valid, input op, input push_value, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/fqdm_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fqdm_out_if: result channel
// Valid/ready channel carrying one operation result per beat.
// ----------------------------------------------------------------------------
interface fqdm_out_if #(
	parameter int DATA_WIDTH = 32,
	parameter int COUNT_WIDTH = 5
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] popped_value;
	logic signed [DATA_WIDTH-1:0] front_value;
	logic [COUNT_WIDTH-1:0]       entry_count;
	logic [1:0]                   status;

	modport source (output valid, output popped_value, output front_value,
		output entry_count, output status, input ready);
	modport sink   (input valid, input popped_value, input front_value,
		input entry_count, input status, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/fifo_queue_drop_above_mean.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_drop_above_mean: bounded FIFO with in-place drop-above-mean
// Circular buffer in one synchronous RAM with push, pop, clear and a filter
// that removes every entry above the truncated mean, keeping survivor order.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+----------------------------------------------
//  cmd     | in  | valid / ready | op, push_value
//  rsp     | out | valid / ready | popped_value, front_value, entry_count, status
//
//  Push and clear answer straight from idle; pop passes through S_POP for one
//  RAM read of the new head. Drop-above-mean runs a read sweep to sum the
//  entries, a bit-serial divide, and a read/write compaction sweep, all
//  through the single RAM read port.
//  Reset clears head, count and the sequencer; RAM contents are undefined and
//  are never used before being written, so there is no clearing pass.
//  cmd stalls while an operation is in progress or a result beat is held
//  and not taken; the result register drains in the same cycle it is refilled.
//
module fifo_queue_drop_above_mean
	import fqdm_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fqdm_in_if.sink     cmd,
	fqdm_out_if.source  rsp
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	// the exact sum of DEPTH signed words, with room for its magnitude
	localparam int SUM_W = DATA_WIDTH + IDX_W + 1;

	// wrap head plus offset into the ring; both operands are below DEPTH
	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
			input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (IDX_W+1)'(DEPTH)) begin
			s = s - (IDX_W+1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	// ring storage
	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_s1;

	// control state
	state_t            state_q, state_d;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  w_q;
	logic              rd_pend_s1;
	logic              out_valid_q;

	// payload registers
	logic signed [SUM_W-1:0]      sum_q;
	logic signed [DATA_WIDTH-1:0] mean_q;
	logic [DATA_WIDTH-1:0]        front_q;
	logic [DATA_WIDTH-1:0]        pop_val_q;
	logic [DATA_WIDTH-1:0]        out_popped_q;
	logic [DATA_WIDTH-1:0]        out_front_q;
	logic [CNT_W-1:0]             out_count_q;
	status_t                      out_status_q;

	// combinational controls
	op_t                   op_in;
	logic                  accept;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic                  keep;
	logic                  div_start;
	logic                  div_done;
	logic [SUM_W-1:0]      div_quo;
	logic [SUM_W-1:0]      sum_mag;
	logic [SUM_W-1:0]      mean_full;
	logic                  sweep_end;
	logic                  out_load;
	logic [DATA_WIDTH-1:0] out_popped_d;
	logic [DATA_WIDTH-1:0] out_front_d;
	logic [CNT_W-1:0]      out_count_d;
	status_t               out_status_d;

	assign op_in     = op_t'(cmd.op);
	assign cmd.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = cmd.valid && cmd.ready;

	// keep entries not above the mean (equal survives)
	assign keep      = !($signed(rd_data_s1) > mean_q);
	assign sweep_end = (k_q == cnt_q) && !rd_pend_s1;

	// divide the magnitude; fix the sign afterward to truncate toward zero
	assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign mean_full = sum_q[SUM_W-1] ? (~div_quo + SUM_W'(1)) : div_quo;

	fqdm_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_mag),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// RAM: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, RAM port steering and result assembly
	always_comb begin
		state_d      = state_q;
		rd_en        = 1'b0;
		rd_addr      = slot(head_q, k_q[IDX_W-1:0]);
		wr_en        = 1'b0;
		wr_addr      = slot(head_q, cnt_q[IDX_W-1:0]);
		wr_data      = cmd.push_value;
		div_start    = 1'b0;
		out_load     = 1'b0;
		out_popped_d = '0;
		out_front_d  = '0;
		out_count_d  = cnt_q;
		out_status_d = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op_in)
						OP_PUSH: begin
							out_load = 1'b1;
							if (cnt_q == CNT_W'(DEPTH)) begin
								out_status_d = ST_FULL;
								out_front_d  = front_q;
							end else begin
								wr_en       = 1'b1;
								out_front_d = (cnt_q == '0) ? cmd.push_value : front_q;
								out_count_d = cnt_q + CNT_W'(1);
							end
						end
						OP_POP: begin
							if (cnt_q == '0) begin
								out_load     = 1'b1;
								out_status_d = ST_EMPTY;
							end else begin
								// fetch the new head
								rd_en   = 1'b1;
								rd_addr = slot(head_q, IDX_W'(1));
								state_d = S_POP;
							end
						end
						OP_CLEAR: begin
							out_load    = 1'b1;
							out_count_d = '0;
						end
						OP_DROP: begin
							if (cnt_q == '0) begin
								out_load     = 1'b1;
								out_status_d = ST_EMPTY;
							end else begin
								state_d = S_SUM;
							end
						end
						default: ;
					endcase
				end
			end
			S_POP: begin
				out_load     = 1'b1;
				out_popped_d = pop_val_q;
				out_front_d  = (cnt_q != '0) ? rd_data_s1 : '0;
				state_d      = S_IDLE;
			end
			S_SUM: begin
				rd_en = (k_q != cnt_q);
				if (sweep_end) begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_FILT;
				end
			end
			S_FILT: begin
				// survivors are written at or behind the read point: no overlap
				rd_en   = (k_q != cnt_q);
				wr_addr = slot(head_q, w_q[IDX_W-1:0]);
				wr_data = rd_data_s1;
				wr_en   = rd_pend_s1 && keep;
				if (sweep_end) begin
					out_load    = 1'b1;
					out_front_d = (w_q != '0) ? front_q : '0;
					out_count_d = w_q;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			w_q         <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_en && (state_q != S_IDLE);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					k_q <= '0;
					w_q <= '0;
					if (accept) begin
						case (op_in)
							OP_PUSH: begin
								if (cnt_q != CNT_W'(DEPTH)) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							OP_POP: begin
								if (cnt_q != '0) begin
									head_q <= slot(head_q, IDX_W'(1));
									cnt_q  <= cnt_q - CNT_W'(1);
								end
							end
							OP_CLEAR: begin
								head_q <= '0;
								cnt_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SUM: begin
					if (rd_en) begin
						k_q <= k_q + CNT_W'(1);
					end
				end
				S_DIV: begin
					k_q <= '0;
					w_q <= '0;
				end
				S_FILT: begin
					if (rd_en) begin
						k_q <= k_q + CNT_W'(1);
					end
					if (wr_en) begin
						w_q <= w_q + CNT_W'(1);
					end
					if (sweep_end) begin
						cnt_q <= w_q;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			sum_q <= '0;
		end else if (state_q == S_SUM && rd_pend_s1) begin
			sum_q <= sum_q + {{(SUM_W-DATA_WIDTH){rd_data_s1[DATA_WIDTH-1]}}, rd_data_s1};
		end
		if (div_done) begin
			mean_q <= $signed(mean_full[DATA_WIDTH-1:0]);
		end
		// track the head word so push and pop results need no extra read
		if (state_q == S_IDLE && accept && op_in == OP_PUSH && cnt_q == '0) begin
			front_q <= cmd.push_value;
		end else if (state_q == S_POP) begin
			front_q <= rd_data_s1;
		end else if (state_q == S_FILT && wr_en && w_q == '0) begin
			front_q <= rd_data_s1;
		end
		if (state_q == S_IDLE && accept && op_in == OP_POP) begin
			pop_val_q <= front_q;
		end
		if (out_load) begin
			out_popped_q <= out_popped_d;
			out_front_q  <= out_front_d;
			out_count_q  <= out_count_d;
			out_status_q <= out_status_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = out_popped_q;
	assign rsp.front_value  = out_front_q;
	assign rsp.entry_count  = out_count_q;
	assign rsp.status       = out_status_q;

endmodule
`default_nettype wire

// ----- hw/rtl/fqdm_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fqdm_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, done pulses with quotient.
// ----------------------------------------------------------------------------
module fqdm_div
	import fqdm_pkg::*;
#(
	parameter int DIVIDEND_W = 37,
	parameter int DIVISOR_W = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       done,
	output logic [DIVIDEND_W-1:0]      quotient
);

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    trial_sub;
	logic                  ge;

	// shift the next dividend bit into the partial remainder and try a subtract
	always_comb begin
		trial     = {rem_q, quo_q[DIVIDEND_W-1]};
		ge        = trial >= {1'b0, dvs_q};
		trial_sub = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVIDEND_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ----- verif/fqdm_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fqdm_checker: result predictor and scoreboard for the drop-above-mean queue
// Watches the command and result channels. Every accepted command updates a
// private copy of the queue and stores the result it should produce. Every
// accepted result beat is compared field by field with the oldest stored one.
// ----------------------------------------------------------------------------
module fqdm_checker
	import fqdm_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int DATA_WIDTH = 32,
	parameter int COUNT_WIDTH = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	fqdm_in_if          cmd,
	fqdm_out_if         rsp,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned checked
);

	localparam int MAX_REPORTS = 30;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] popped;
		logic signed [DATA_WIDTH-1:0] front;
		logic [COUNT_WIDTH-1:0]       count;
		status_t                      status;
	} outcome_t;

	logic signed [DATA_WIDTH-1:0] queue_words[$];
	outcome_t                     pending_results[$];
	int unsigned                  mismatch_total = 0;
	int unsigned                  pending_total = 0;
	int unsigned                  beats_checked = 0;

	assign fail_count = mismatch_total;
	assign pending    = pending_total;
	assign checked    = beats_checked;

	task automatic flag_error(input string line);
		mismatch_total++;
		if (mismatch_total <= MAX_REPORTS)
			$display("checker: %0t %s", $realtime, line);
	endtask

	// Apply one operation to the private queue and return the result it gives.
	function automatic outcome_t apply_queue_op(input op_t op,
		input logic signed [DATA_WIDTH-1:0] word);
		outcome_t                     res;
		longint                       total;
		longint                       mean;
		logic signed [DATA_WIDTH-1:0] kept[$];
		res        = '0;
		res.status = ST_OK;
		case (op)
			OP_PUSH: begin
				if (queue_words.size() >= DEPTH)
					res.status = ST_FULL;
				else
					queue_words.push_back(word);
			end
			OP_POP: begin
				if (queue_words.size() == 0)
					res.status = ST_EMPTY;
				else
					res.popped = queue_words.pop_front();
			end
			OP_CLEAR: begin
				queue_words.delete();
			end
			default: begin
				if (queue_words.size() == 0) begin
					res.status = ST_EMPTY;
				end else begin
					// 64-bit sum is exact; signed division truncates toward zero
					total = 0;
					foreach (queue_words[i])
						total += queue_words[i];
					mean = total / longint'(queue_words.size());
					foreach (queue_words[i])
						if (queue_words[i] <= mean)
							kept.push_back(queue_words[i]);
					queue_words = kept;
				end
			end
		endcase
		res.front = (queue_words.size() != 0) ? queue_words[0] : '0;
		res.count = COUNT_WIDTH'(queue_words.size());
		return res;
	endfunction

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (cmd.valid && cmd.ready)
				pending_results.push_back(apply_queue_op(op_t'(cmd.op), cmd.push_value));
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					flag_error("result beat with no command outstanding");
				end else begin
					want = pending_results.pop_front();
					if (rsp.popped_value !== want.popped)
						flag_error($sformatf("beat %0d popped_value %0d, want %0d",
							beats_checked, rsp.popped_value, $signed(want.popped)));
					if (rsp.front_value !== want.front)
						flag_error($sformatf("beat %0d front_value %0d, want %0d",
							beats_checked, rsp.front_value, $signed(want.front)));
					if (rsp.entry_count !== want.count)
						flag_error($sformatf("beat %0d entry_count %0d, want %0d",
							beats_checked, rsp.entry_count, want.count));
					if (rsp.status !== want.status)
						flag_error($sformatf("beat %0d status %0d, want %0d",
							beats_checked, rsp.status, want.status));
				end
				beats_checked++;
			end
			pending_total = pending_results.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for the drop-above-mean queue
// Drives a directed opening (empty and full edges, extreme words, mean
// truncation, ties with the mean, head wrap) and then random episodes of
// push, pop, clear and drop commands under random idling on both channels.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb;
	import fqdm_pkg::*;

	localparam int DEPTH         = 16;
	localparam int DATA_WIDTH    = 32;
	localparam int COUNT_WIDTH   = 5;
	localparam int CLK_PERIOD    = 10;
	localparam int RANDOM_ITEMS  = 1050;
	// Settle time after the drain, padded past a full drop sweep.
	localparam int SETTLE_CYCLES = 120;
	// Worst case per command: drop sweep, longest sender gap, longest stall.
	// The limit is that worst case for about 1100 commands, several times over.
	localparam int LIMIT_CYCLES  = 700000;

	localparam logic [DATA_WIDTH-1:0] WORD_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] WORD_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [DATA_WIDTH-1:0] WORD_ONES = {DATA_WIDTH{1'b1}};

	// Random stimulus comes in episodes, each biased toward one kind of use.
	typedef enum int {
		EP_FILL,
		EP_DRAIN,
		EP_FILTER,
		EP_NOISE
	} episode_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	// Shared switch for stretches where neither side idles.
	bit          no_stall = 1'b0;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned checked;
	int unsigned op_sent[4];
	int unsigned sent_total = 0;

	fqdm_in_if  #(.DATA_WIDTH(DATA_WIDTH)) cmd ();
	fqdm_out_if #(.DATA_WIDTH(DATA_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) rsp ();

	fifo_queue_drop_above_mean #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	fqdm_checker #(
		.DEPTH       (DEPTH),
		.DATA_WIDTH  (DATA_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Idle gap before a command beat: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_stall || r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Mix full-range words (every bit toggles) with small values, where ties
	// with the mean and negative truncation show up often, and the extremes.
	function automatic logic [DATA_WIDTH-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return DATA_WIDTH'($urandom);
		if (r < 70)
			return DATA_WIDTH'($signed($urandom_range(0, 32)) - 16);
		if (r < 90)
			return DATA_WIDTH'($signed($urandom_range(0, 2000)) - 1000);
		case ($urandom_range(0, 3))
			0:       return WORD_MAX;
			1:       return WORD_MIN;
			2:       return '0;
			default: return WORD_ONES;
		endcase
	endfunction

	function automatic op_t pick_op(input episode_t kind);
		int r;
		r = $urandom_range(0, 99);
		case (kind)
			EP_FILL: begin
				// push hard enough to run into the full limit
				if (r < 88) return OP_PUSH;
				if (r < 96) return OP_DROP;
				return OP_POP;
			end
			EP_DRAIN: begin
				if (r < 80) return OP_POP;
				if (r < 92) return OP_DROP;
				if (r < 97) return OP_PUSH;
				return OP_CLEAR;
			end
			EP_FILTER: begin
				if (r < 60) return OP_PUSH;
				if (r < 85) return OP_DROP;
				if (r < 97) return OP_POP;
				return OP_CLEAR;
			end
			default: begin
				if (r < 35) return OP_PUSH;
				if (r < 65) return OP_POP;
				if (r < 90) return OP_DROP;
				return OP_CLEAR;
			end
		endcase
	endfunction

	// Present one command beat and hold it until the block takes it. Called
	// just after the clock rises; valid stays high when there is no gap, so it
	// is never lowered and raised in the same step.
	task automatic send_beat(input op_t op, input logic [DATA_WIDTH-1:0] word);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid      <= 1'b1;
		cmd.op         <= op;
		cmd.push_value <= word;
		do
			@(posedge clk);
		while (!cmd.ready);
		op_sent[op]++;
		sent_total++;
	endtask

	// Result side: stall ready at random and now and then flip into or out of
	// a stretch with no idling on either side.
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 299) == 0)
				no_stall = !no_stall;
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (no_stall || r < 70) begin
					rsp.ready <= 1'b1;
				end else begin
					// hold ready low, then keep it low while stall_left counts down
					stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 30);
					rsp.ready <= 1'b0;
				end
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		episode_t kind;
		int       len;
		int       directed_count;
		cmd.valid      <= 1'b0;
		cmd.op         <= OP_PUSH;
		cmd.push_value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue: pop and drop both report empty and change nothing.
		send_beat(OP_POP, '0);
		send_beat(OP_DROP, WORD_ONES);
		// Extreme words; the mean of these is -1/5, which truncates to zero.
		send_beat(OP_PUSH, WORD_MAX);
		send_beat(OP_PUSH, WORD_MIN);
		send_beat(OP_PUSH, '0);
		send_beat(OP_PUSH, WORD_ONES);
		send_beat(OP_PUSH, DATA_WIDTH'(1));
		send_beat(OP_DROP, '0);
		send_beat(OP_POP, '0);
		// Clear with entries, then clear when already empty.
		send_beat(OP_CLEAR, '0);
		send_beat(OP_CLEAR, '0);
		// Negative mean -10/3 truncates to -3; the entry equal to it is kept.
		send_beat(OP_PUSH, -DATA_WIDTH'(5));
		send_beat(OP_PUSH, -DATA_WIDTH'(2));
		send_beat(OP_PUSH, -DATA_WIDTH'(3));
		send_beat(OP_DROP, '0);
		// Advance the head off slot zero so filling to the limit wraps.
		send_beat(OP_POP, '0);
		for (int k = 0; k < DEPTH; k++)
			send_beat(OP_PUSH, (k % 2) ? {(DATA_WIDTH/2){2'b01}} : {(DATA_WIDTH/2){2'b10}});
		// Push into a full queue is dropped; then filter the full queue.
		send_beat(OP_PUSH, WORD_MAX);
		send_beat(OP_DROP, '0);
		send_beat(OP_CLEAR, '0);
		directed_count = sent_total;

		// Random episodes until the item budget is spent.
		while (sent_total < directed_count + RANDOM_ITEMS) begin
			kind = episode_t'($urandom_range(0, 3));
			len  = $urandom_range(4, 20);
			for (int k = 0; k < len; k++)
				send_beat(pick_op(kind), pick_word());
		end
		cmd.valid <= 1'b0;

		// Drain: wait for every outstanding result, then let a drop sweep's
		// worth of cycles pass to catch stray beats.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("tb: %0d commands (push %0d, pop %0d, clear %0d, drop %0d)",
			sent_total, op_sent[OP_PUSH], op_sent[OP_POP], op_sent[OP_CLEAR],
			op_sent[OP_DROP]);
		$display("tb: %0d result beats compared, %0d mismatches, %0d outstanding",
			checked, fail_count, pending);
		if (fail_count == 0 && pending == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// Watchdog: end the run if the block stops making progress.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("tb: timeout after %0d cycles, %0d results outstanding",
			LIMIT_CYCLES, pending);
		$display("tb: done, errors");
		$finish;
	end

endmodule
